// ===== rtl/msq_pkg.sv =====
`default_nettype none
package msq_pkg;

    localparam int MSQ_DEPTH   = 256;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_MIN  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } res_t;

    typedef enum logic [1:0] {
        K_PUSH,
        K_POP,
        K_MIN
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_POP_RD
    } bk_state_t;

endpackage
`default_nettype wire

// ===== rtl/msq_front.sv =====
`default_nettype none
module msq_front
    import msq_pkg::*;
(
    input  wire logic start,
    input  wire req_t request,
    input  wire logic q_full,
    output logic      busy,
    output logic      q_wr,
    output cmd_t      q_cmd
);

    always_comb
    begin
        q_cmd.value = request.push_value;
        q_cmd.kind  = K_PUSH;
        q_wr        = 1'b0;
        unique case (request.opcode)
            OP_PUSH:
            begin
                q_cmd.kind = K_PUSH;
                q_wr       = start && !q_full;
            end
            OP_POP:
            begin
                q_cmd.kind = K_POP;
                q_wr       = start && !q_full;
            end
            OP_MIN:
            begin
                q_cmd.kind = K_MIN;
                q_wr       = start && !q_full;
            end
            // unused opcode: taken and dropped
            default:
            begin
                q_wr = 1'b0;
            end
        endcase
    end

    assign busy = q_full;

endmodule
`default_nettype wire

// ===== rtl/msq_queue.sv =====
`default_nettype none
module msq_queue
    import msq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire cmd_t wr_cmd,
    input  wire logic rd,
    output cmd_t      head,
    output logic      empty,
    output logic      full
);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = QPW'(wr_ptr_reg + 1'b1);
        end
        if (rd)
        begin
            rd_ptr_next = QPW'(rd_ptr_reg + 1'b1);
        end
        if (wr && !rd)
        begin
            count_next = QCW'(count_reg + 1'b1);
        end
        else if (rd && !wr)
        begin
            count_next = QCW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/msq_back.sv =====
`default_nettype none
module msq_back
    import msq_pkg::*;
#(
    parameter int STACK_DEPTH = MSQ_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head,
    input  wire logic q_empty,
    output logic      q_rd,
    output logic      done,
    output res_t      result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [31:0] stack_mem [STACK_DEPTH];
    logic signed [31:0] min_mem   [STACK_DEPTH];

    bk_state_t          state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] top_min_reg, top_min_next;
    logic               done_reg, done_next;
    res_t               result_reg, result_next;
    logic signed [31:0] val_rd_reg, min_rd_reg;

    logic [CW-1:0]      cnt_m1, cnt_m2;
    logic [AW-1:0]      wr_idx, top_idx, below_idx;
    logic               mem_we;
    logic signed [31:0] push_min;

    assign cnt_m1    = CW'(count_reg - 1'b1);
    assign cnt_m2    = CW'(count_reg - 2'd2);
    assign wr_idx    = count_reg[AW-1:0];
    assign top_idx   = cnt_m1[AW-1:0];
    assign below_idx = cnt_m2[AW-1:0];

    // running minimum seen by the new top entry
    assign push_min = (count_reg == '0 || head.value < top_min_reg) ? head.value : top_min_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_min_next = top_min_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        q_rd         = 1'b0;
        mem_we       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd = 1'b1;
                    unique case (head.kind)
                        K_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                done_next                = 1'b1;
                                result_next.result_value = '0;
                                result_next.status       = ST_FULL;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                top_min_next = push_min;
                                count_next   = CW'(count_reg + 1'b1);
                            end
                        end
                        K_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next                = 1'b1;
                                result_next.result_value = '0;
                                result_next.status       = ST_EMPTY;
                            end
                            else
                            begin
                                // memory reads land next cycle
                                count_next = cnt_m1;
                                state_next = BK_POP_RD;
                            end
                        end
                        K_MIN:
                        begin
                            done_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                result_next.result_value = '0;
                                result_next.status       = ST_EMPTY;
                            end
                            else
                            begin
                                result_next.result_value = top_min_reg;
                                result_next.status       = ST_OK;
                            end
                        end
                        default:
                        begin
                            q_rd = 1'b1;
                        end
                    endcase
                end
            end
            BK_POP_RD:
            begin
                done_next                = 1'b1;
                result_next.result_value = val_rd_reg;
                result_next.status       = ST_OK;
                if (count_reg != '0)
                begin
                    top_min_next = min_rd_reg;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_min_reg <= top_min_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_idx] <= head.value;
            min_mem[wr_idx]   <= push_min;
        end
        val_rd_reg <= stack_mem[top_idx];
        min_rd_reg <= min_mem[below_idx];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== rtl/stack_with_minimum_query_unit.sv =====
// channel   | signals               | handshake
// ----------+-----------------------+-------------------------------------
// request   | start, busy, request  | item taken when start && !busy
// result    | done, result          | one-cycle strobe, cannot be held off
//
// push and minimum are handled in the back end's idle state, pop also in its read
// state (registered read of the value and minimum memories); a successful push
// gives no strobe, only a full stack does (ST_FULL); a queued item waits its turn.
// a 4-item queue decouples the request side; busy is high only while it is full.
// reset clears the queue, entry count and state; the memories are not cleared.
// an unused opcode is taken and gives no result.
`default_nettype none
module stack_with_minimum_query_unit
    import msq_pkg::*;
#(
    parameter int STACK_DEPTH = MSQ_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t request,
    output logic      busy,
    output logic      done,
    output res_t      result
);

    logic q_wr, q_rd, q_empty, q_full;
    cmd_t q_cmd, q_head;

    msq_front u_front (
        .start   (start),
        .request (request),
        .q_full  (q_full),
        .busy    (busy),
        .q_wr    (q_wr),
        .q_cmd   (q_cmd)
    );

    msq_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_cmd (q_cmd),
        .rd     (q_rd),
        .head   (q_head),
        .empty  (q_empty),
        .full   (q_full)
    );

    msq_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .done    (done),
        .result  (result)
    );

endmodule
`default_nettype wire
